[hdl/assert_macros.svh]
// assertion helpers for the rtl
// each macro expects clk and rst_n in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ffha_pkg.sv]
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and constants of the first-fit boundary-tag heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  typedef enum logic [1:0] {
    OP_INIT    = 2'd0,
    OP_MALLOC  = 2'd1,
    OP_FREE    = 2'd2,
    OP_REALLOC = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NULL   = 2'd1,
    ST_NOMEM  = 2'd2,
    ST_UNINIT = 2'd3
  } status_t;

  localparam logic [31:0] WSIZE     = 32'd4;
  localparam logic [31:0] DSIZE     = 32'd8;
  localparam logic [31:0] MIN_SPLIT = 32'd16;
  localparam logic [31:0] ALLOC_BIT = 32'h1;
  localparam logic [31:0] SIZE_MASK = 32'hFFFF_FFF8;

  // size field of a boundary tag
  function automatic logic [31:0] tag_size(input logic [31:0] w);
    return w & SIZE_MASK;
  endfunction

endpackage

[hdl/ffha_cmd_if.sv]
// ----------------------------------------------------------------------------
// ffha_cmd_if
// Command channel of the heap allocator: valid/ready plus one command word.
// ----------------------------------------------------------------------------
interface ffha_cmd_if;
  import ffha_pkg::*;

  logic        valid;
  logic        ready;
  opcode_t     opcode;
  logic [15:0] request_size;
  logic [15:0] block_ptr;

  modport source (output valid, output opcode, output request_size, output block_ptr,
                  input ready);
  modport sink   (input valid, input opcode, input request_size, input block_ptr,
                  output ready);
endinterface

[hdl/ffha_rsp_if.sv]
// ----------------------------------------------------------------------------
// ffha_rsp_if
// Response channel of the heap allocator: valid/ready plus one result word.
// ----------------------------------------------------------------------------
interface ffha_rsp_if;
  import ffha_pkg::*;

  logic        valid;
  logic        ready;
  logic [15:0] result_ptr;
  status_t     status;
  logic [15:0] copy_bytes;

  modport source (output valid, output result_ptr, output status, output copy_bytes,
                  input ready);
  modport sink   (input valid, input result_ptr, input status, input copy_bytes,
                  output ready);
endinterface

[hdl/first_fit_heap_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// Implicit-list first-fit allocator with header/footer boundary tags over an
// on-chip word memory; init, malloc, free and realloc commands.
// ----------------------------------------------------------------------------
//   channel  | dir | handshake     | word
//   in_cmd   | in  | valid / ready | opcode, request_size, block_ptr
//   out_rsp  | out | valid / ready | result_ptr, status, copy_bytes
//
// One command at a time; every heap access goes through the single memory
// port (one read and one write per cycle, registered read data). The sequencer
// is back in idle as out_rsp.valid rises. Malloc walks the blocks first-fit
// and grows the heap on a miss; free clears both tags and coalesces; realloc
// mallocs, reads the old block's size for the copy length, then frees.
// No clearing pass after reset: the heap is laid down by init.
// A waiting response does not block the next command; the sequencer only
// holds in its final step if the response register is still full.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES  = 65536,  // power of two
  parameter int CHUNK_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  ffha_cmd_if.sink    in_cmd,
  ffha_rsp_if.source  out_rsp
);
  import ffha_pkg::*;
  `include "assert_macros.svh"

  localparam int HEAP_WORDS = HEAP_BYTES / 4;
  localparam int AW         = $clog2(HEAP_WORDS);
  localparam int WALK_LIMIT = HEAP_BYTES / 8 + 2;
  localparam int CW         = $clog2(WALK_LIMIT + 1);
  localparam int BW         = $clog2(HEAP_BYTES + 1);

  typedef enum logic [5:0] {
    S_IDLE, S_DISPATCH, S_INIT_W,
    S_EX_START, S_EX_W0, S_EX_W1, S_EX_W2, S_EX_DONE,
    S_CO_RD0, S_CO_RD1, S_CO_RD2, S_CO_RD3, S_CO_RD4, S_CO_EVAL,
    S_CO_PA_W, S_CO_NA_R, S_CO_NA_W, S_CO_BO_R, S_CO_BO_N, S_CO_BO_W,
    S_CO_PRV_R, S_CO_PRV, S_CO_END,
    S_MA_START, S_FF_RD, S_FF_CHK,
    S_PL_RD, S_PL_W0, S_PL_W1, S_PL_W2, S_PL_W3, S_MAL_DONE,
    S_RA_RD, S_RA_CP, S_FR_RD, S_FR_W0, S_FR_W1, S_DONE
  } state_t;

  // heap memory
  logic [31:0] heap_mem [HEAP_WORDS];
  logic [31:0] mem_q;
  logic        mem_we;
  logic [31:0] mem_waddr, mem_wdata, mem_raddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      heap_mem[mem_waddr[AW+1:2]] <= mem_wdata;
    end
    mem_q <= heap_mem[mem_raddr[AW+1:2]];
  end

  // sequencer registers
  state_t      state_r, state_nxt;
  opcode_t     op_r, op_nxt;
  logic [15:0] size_r, size_nxt;
  logic [15:0] ptr_r, ptr_nxt;
  logic [31:0] bp_r, bp_nxt;
  logic [31:0] tmp_r, tmp_nxt;
  logic [31:0] asize_r, asize_nxt;
  logic [31:0] sz_r, sz_nxt;
  logic [31:0] ps_r, ps_nxt;
  logic        pa_r, pa_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [BW-1:0] brk_r, brk_nxt;
  logic [15:0] list_r, list_nxt;
  logic        init_r, init_nxt;
  logic        ext_r, ext_nxt;
  logic [15:0] res_r, res_nxt;
  status_t     st_r, st_nxt;
  logic [15:0] cp_r, cp_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_ptr_r, out_ptr_nxt;
  status_t     out_st_r, out_st_nxt;
  logic [15:0] out_cp_r, out_cp_nxt;

  // shared datapath terms
  logic [31:0] q_size;
  logic [31:0] ext_bytes, ext_words, ext_size;
  logic [32:0] grow_end;
  logic [31:0] rem_size, cp_full;
  logic        split;

  always_comb begin
    q_size    = tag_size(mem_q);
    ext_bytes = (op_r == OP_INIT) ? 32'(CHUNK_BYTES) :
                ((asize_r > 32'(CHUNK_BYTES)) ? asize_r : 32'(CHUNK_BYTES));
    ext_words = ext_bytes >> 2;
    ext_size  = (ext_words + {31'd0, ext_words[0]}) << 2;
    grow_end  = {1'b0, 32'(brk_r)} + {1'b0, ext_size};
    rem_size  = sz_r - asize_r;
    split     = rem_size >= MIN_SPLIT;
    cp_full   = q_size - DSIZE;
  end

  always_comb begin
    state_nxt = state_r;  op_nxt = op_r;  size_nxt = size_r;  ptr_nxt = ptr_r;
    bp_nxt = bp_r;  tmp_nxt = tmp_r;  asize_nxt = asize_r;  sz_nxt = sz_r;
    ps_nxt = ps_r;  pa_nxt = pa_r;  cnt_nxt = cnt_r;  brk_nxt = brk_r;
    list_nxt = list_r;  init_nxt = init_r;  ext_nxt = ext_r;
    res_nxt = res_r;  st_nxt = st_r;  cp_nxt = cp_r;
    out_valid_nxt = out_valid_r;  out_ptr_nxt = out_ptr_r;
    out_st_nxt = out_st_r;  out_cp_nxt = out_cp_r;
    mem_we = 1'b0;  mem_waddr = '0;  mem_wdata = '0;  mem_raddr = '0;

    // response taken
    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_cmd.valid) begin
          op_nxt    = in_cmd.opcode;
          size_nxt  = in_cmd.request_size;
          ptr_nxt   = in_cmd.block_ptr;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        res_nxt = '0;
        st_nxt  = ST_OK;
        cp_nxt  = '0;
        if (op_r == OP_INIT) begin
          brk_nxt   = BW'(4 * 4);
          init_nxt  = 1'b0;
          list_nxt  = 16'(2 * WSIZE);
          cnt_nxt   = '0;
          state_nxt = S_INIT_W;
        end else if (!init_r) begin
          st_nxt    = ST_UNINIT;
          state_nxt = S_DONE;
        end else begin
          unique case (op_r)
            OP_INIT, OP_MALLOC: state_nxt = S_MA_START;
            OP_FREE: begin
              if (ptr_r == '0) begin
                st_nxt    = ST_NULL;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_FR_RD;
              end
            end
            OP_REALLOC: begin
              if (size_r == '0) begin
                st_nxt    = ST_NULL;
                state_nxt = (ptr_r != '0) ? S_FR_RD : S_DONE;
              end else begin
                state_nxt = S_MA_START;
              end
            end
          endcase
        end
      end
      // padding, prologue header and footer, epilogue
      S_INIT_W: begin
        mem_we    = 1'b1;
        mem_waddr = 32'(cnt_r) << 2;
        mem_wdata = (cnt_r == CW'(0)) ? 32'd0 :
                    (cnt_r == CW'(3)) ? ALLOC_BIT : (DSIZE | ALLOC_BIT);
        cnt_nxt   = cnt_r + CW'(1);
        if (cnt_r == CW'(3)) begin
          state_nxt = S_EX_START;
        end
      end
      // heap growth
      S_EX_START: begin
        if (grow_end > 33'(HEAP_BYTES)) begin
          bp_nxt    = '0;
          state_nxt = S_EX_DONE;
        end else begin
          bp_nxt    = 32'(brk_r);
          brk_nxt   = BW'(grow_end);
          sz_nxt    = ext_size;
          state_nxt = S_EX_W0;
        end
      end
      S_EX_W0: begin
        mem_we = 1'b1;  mem_waddr = bp_r - WSIZE;  mem_wdata = sz_r;
        state_nxt = S_EX_W1;
      end
      S_EX_W1: begin
        mem_we = 1'b1;  mem_waddr = bp_r + sz_r - DSIZE;  mem_wdata = sz_r;
        state_nxt = S_EX_W2;
      end
      S_EX_W2: begin
        mem_we = 1'b1;  mem_waddr = bp_r + sz_r - WSIZE;  mem_wdata = ALLOC_BIT;
        ext_nxt   = 1'b1;
        state_nxt = S_CO_RD0;
      end
      S_EX_DONE: begin
        if (op_r == OP_INIT) begin
          if (bp_r != '0) begin
            init_nxt = 1'b1;
          end else begin
            st_nxt = ST_NOMEM;
          end
          state_nxt = S_DONE;
        end else if (bp_r == '0) begin
          st_nxt    = ST_NOMEM;
          res_nxt   = '0;
          state_nxt = S_MAL_DONE;
        end else begin
          state_nxt = S_PL_RD;
        end
      end
      // coalesce: gather both neighbors' tags
      S_CO_RD0: begin
        mem_raddr = bp_r - DSIZE;
        state_nxt = S_CO_RD1;
      end
      S_CO_RD1: begin
        tmp_nxt   = bp_r - q_size;
        mem_raddr = bp_r - q_size - WSIZE;
        state_nxt = S_CO_RD2;
      end
      S_CO_RD2: begin
        ps_nxt    = q_size;
        mem_raddr = tmp_r + q_size - DSIZE;
        state_nxt = S_CO_RD3;
      end
      S_CO_RD3: begin
        pa_nxt    = mem_q[0];
        mem_raddr = bp_r - WSIZE;
        state_nxt = S_CO_RD4;
      end
      S_CO_RD4: begin
        sz_nxt    = q_size;
        mem_raddr = bp_r + q_size - WSIZE;
        state_nxt = S_CO_EVAL;
      end
      S_CO_EVAL: begin
        if (pa_r && mem_q[0]) begin
          state_nxt = S_CO_END;
        end else if (pa_r) begin
          sz_nxt = sz_r + q_size;
          mem_we = 1'b1;  mem_waddr = bp_r - WSIZE;  mem_wdata = sz_r + q_size;
          state_nxt = S_CO_PA_W;
        end else if (mem_q[0]) begin
          sz_nxt = sz_r + ps_r;
          mem_we = 1'b1;  mem_waddr = bp_r + sz_r - DSIZE;  mem_wdata = sz_r + ps_r;
          state_nxt = S_CO_NA_R;
        end else begin
          sz_nxt = sz_r + ps_r + q_size;
          mem_we = 1'b1;  mem_waddr = tmp_r - WSIZE;  mem_wdata = sz_r + ps_r + q_size;
          state_nxt = S_CO_BO_R;
        end
      end
      S_CO_PA_W: begin
        mem_we = 1'b1;  mem_waddr = bp_r + sz_r - DSIZE;  mem_wdata = sz_r;
        state_nxt = S_CO_END;
      end
      // previous neighbor free: tags are re-read after each write
      S_CO_NA_R: begin
        mem_raddr = bp_r - DSIZE;
        state_nxt = S_CO_NA_W;
      end
      S_CO_NA_W: begin
        mem_we = 1'b1;  mem_waddr = bp_r - q_size - WSIZE;  mem_wdata = sz_r;
        state_nxt = S_CO_PRV_R;
      end
      // both neighbors free
      S_CO_BO_R: begin
        mem_raddr = bp_r - WSIZE;
        state_nxt = S_CO_BO_N;
      end
      S_CO_BO_N: begin
        tmp_nxt   = bp_r + q_size;
        mem_raddr = bp_r + q_size - WSIZE;
        state_nxt = S_CO_BO_W;
      end
      S_CO_BO_W: begin
        mem_we = 1'b1;  mem_waddr = tmp_r + q_size - DSIZE;  mem_wdata = sz_r;
        state_nxt = S_CO_PRV_R;
      end
      S_CO_PRV_R: begin
        mem_raddr = bp_r - DSIZE;
        state_nxt = S_CO_PRV;
      end
      S_CO_PRV: begin
        bp_nxt    = bp_r - q_size;
        state_nxt = S_CO_END;
      end
      S_CO_END: begin
        ext_nxt   = 1'b0;
        state_nxt = ext_r ? S_EX_DONE : S_DONE;
      end
      // malloc: round request, then first-fit walk
      S_MA_START: begin
        if (size_r == '0) begin
          st_nxt    = ST_NULL;
          res_nxt   = '0;
          state_nxt = S_MAL_DONE;
        end else begin
          asize_nxt = (32'(size_r) + DSIZE + DSIZE - 32'd1) & SIZE_MASK;
          bp_nxt    = 32'(list_r);
          cnt_nxt   = '0;
          state_nxt = S_FF_RD;
        end
      end
      S_FF_RD: begin
        mem_raddr = bp_r - WSIZE;
        state_nxt = S_FF_CHK;
      end
      S_FF_CHK: begin
        if (cnt_r == CW'(WALK_LIMIT) || q_size == '0) begin
          state_nxt = S_EX_START;
        end else if (!mem_q[0] && asize_r <= q_size) begin
          state_nxt = (bp_r != '0) ? S_PL_RD : S_EX_START;
        end else begin
          bp_nxt    = bp_r + q_size;
          cnt_nxt   = cnt_r + CW'(1);
          mem_raddr = bp_r + q_size - WSIZE;
        end
      end
      // place with optional split
      S_PL_RD: begin
        mem_raddr = bp_r - WSIZE;
        state_nxt = S_PL_W0;
      end
      S_PL_W0: begin
        sz_nxt    = q_size;
        mem_we    = 1'b1;
        mem_waddr = bp_r - WSIZE;
        mem_wdata = ((q_size - asize_r) >= MIN_SPLIT) ? (asize_r | ALLOC_BIT) :
                                                         (q_size | ALLOC_BIT);
        state_nxt = S_PL_W1;
      end
      S_PL_W1: begin
        mem_we = 1'b1;
        if (split) begin
          mem_waddr = bp_r + asize_r - DSIZE;
          mem_wdata = asize_r | ALLOC_BIT;
          state_nxt = S_PL_W2;
        end else begin
          mem_waddr = bp_r + sz_r - DSIZE;
          mem_wdata = sz_r | ALLOC_BIT;
          res_nxt   = bp_r[15:0];
          st_nxt    = ST_OK;
          state_nxt = S_MAL_DONE;
        end
      end
      S_PL_W2: begin
        mem_we = 1'b1;  mem_waddr = bp_r + asize_r - WSIZE;  mem_wdata = rem_size;
        state_nxt = S_PL_W3;
      end
      S_PL_W3: begin
        mem_we = 1'b1;  mem_waddr = bp_r + sz_r - DSIZE;  mem_wdata = rem_size;
        res_nxt   = bp_r[15:0];
        st_nxt    = ST_OK;
        state_nxt = S_MAL_DONE;
      end
      S_MAL_DONE: begin
        state_nxt = (op_r == OP_REALLOC && ptr_r != '0 && st_r == ST_OK) ? S_RA_RD :
                                                                           S_DONE;
      end
      // realloc copy length from the old block
      S_RA_RD: begin
        mem_raddr = 32'(ptr_r) - WSIZE;
        state_nxt = S_RA_CP;
      end
      S_RA_CP: begin
        cp_nxt    = (32'(size_r) < cp_full) ? size_r : cp_full[15:0];
        state_nxt = S_FR_RD;
      end
      // free: clear allocated bit in both tags, then coalesce
      S_FR_RD: begin
        bp_nxt    = 32'(ptr_r);
        mem_raddr = 32'(ptr_r) - WSIZE;
        state_nxt = S_FR_W0;
      end
      S_FR_W0: begin
        sz_nxt = q_size;
        mem_we = 1'b1;  mem_waddr = bp_r - WSIZE;  mem_wdata = q_size;
        state_nxt = S_FR_W1;
      end
      S_FR_W1: begin
        mem_we = 1'b1;  mem_waddr = bp_r + sz_r - DSIZE;  mem_wdata = sz_r;
        ext_nxt   = 1'b0;
        state_nxt = S_CO_RD0;
      end
      S_DONE: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt = 1'b1;
          out_ptr_nxt   = res_r;
          out_st_nxt    = st_r;
          out_cp_nxt    = cp_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      brk_r       <= '0;
      list_r      <= '0;
      init_r      <= 1'b0;
      ext_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      brk_r       <= brk_nxt;
      list_r      <= list_nxt;
      init_r      <= init_nxt;
      ext_r       <= ext_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r      <= op_nxt;
    size_r    <= size_nxt;
    ptr_r     <= ptr_nxt;
    bp_r      <= bp_nxt;
    tmp_r     <= tmp_nxt;
    asize_r   <= asize_nxt;
    sz_r      <= sz_nxt;
    ps_r      <= ps_nxt;
    pa_r      <= pa_nxt;
    res_r     <= res_nxt;
    st_r      <= st_nxt;
    cp_r      <= cp_nxt;
    out_ptr_r <= out_ptr_nxt;
    out_st_r  <= out_st_nxt;
    out_cp_r  <= out_cp_nxt;
  end

  // ports
  assign in_cmd.ready       = (state_r == S_IDLE);
  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.result_ptr = out_ptr_r;
  assign out_rsp.status     = out_st_r;
  assign out_rsp.copy_bytes = out_cp_r;

  // checks
  `ASSERT_ALWAYS(a_brk_in_heap, 33'(brk_r) <= 33'(HEAP_BYTES), "break past heap end")
  `ASSERT_ALWAYS(a_walk_bound, cnt_r <= CW'(WALK_LIMIT), "walk counter past bound")
  `ASSERT_NEXT(a_accept_dispatch, in_cmd.valid && in_cmd.ready, state_r == S_DISPATCH, "lost word")
  `ASSERT_IMPL(a_init_only_by_init, $rose(init_r), $past(op_r) == OP_INIT, "ready outside init")

endmodule

[tb/sv/ffha_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ffha_checker
// Watches the command and response channels of the heap allocator, keeps its
// own boundary-tag heap image, predicts each response word and compares it.
// ----------------------------------------------------------------------------
module ffha_checker #(
  parameter int HEAP_BYTES  = 65536,
  parameter int CHUNK_BYTES = 4096
) (
  input  logic clk,
  input  logic rst_n,
  ffha_cmd_if  cmd,
  ffha_rsp_if  rsp,
  output int   fail_count,
  output int   rsp_waiting
);
  import ffha_pkg::*;

  localparam int HEAP_WORDS = HEAP_BYTES / 4;
  localparam int WALK_LIMIT = HEAP_BYTES / 8 + 2;

  typedef struct packed {
    logic [15:0] ptr;
    status_t     st;
    logic [15:0] cp;
  } alloc_rsp_t;

  // shadow heap; entries appear when written
  logic [31:0] heap_img [int unsigned];
  logic [31:0] brk;
  logic [31:0] list_head;
  bit          heap_ready;
  alloc_rsp_t  rsp_q [$];

  function automatic logic [31:0] rdw(logic [31:0] a);
    int unsigned i;
    i = (a >> 2) % HEAP_WORDS;
    if (heap_img.exists(i)) return heap_img[i];
    return 32'd0;
  endfunction

  function automatic void wrw(logic [31:0] a, logic [31:0] v);
    heap_img[(a >> 2) % HEAP_WORDS] = v;
  endfunction

  function automatic logic [31:0] sz_at(logic [31:0] a);
    return rdw(a) & ~32'h7;
  endfunction

  function automatic logic [31:0] al_at(logic [31:0] a);
    return rdw(a) & 32'h1;
  endfunction

  function automatic logic [31:0] hdr(logic [31:0] bp);
    return bp - WSIZE;
  endfunction

  function automatic logic [31:0] ftr(logic [31:0] bp);
    return bp + sz_at(bp - WSIZE) - DSIZE;
  endfunction

  function automatic logic [31:0] nxt(logic [31:0] bp);
    return bp + sz_at(bp - WSIZE);
  endfunction

  function automatic logic [31:0] prv(logic [31:0] bp);
    return bp - sz_at(bp - DSIZE);
  endfunction

  function automatic bit bump_break(logic [31:0] incr, output logic [31:0] old);
    old = brk;
    if (longint'(brk) + longint'(incr) > longint'(HEAP_BYTES)) return 1'b0;
    brk = brk + incr;
    return 1'b1;
  endfunction

  function automatic logic [31:0] merge_free(logic [31:0] bp);
    logic [31:0] pa, na, sz;
    pa = al_at(ftr(prv(bp)));
    na = al_at(hdr(nxt(bp)));
    sz = sz_at(hdr(bp));
    if (pa != 0 && na != 0) return bp;
    if (pa != 0) begin
      sz += sz_at(hdr(nxt(bp)));
      wrw(hdr(bp), sz);
      wrw(ftr(bp), sz);
    end else if (na != 0) begin
      sz += sz_at(hdr(prv(bp)));
      wrw(ftr(bp), sz);
      wrw(hdr(prv(bp)), sz);
      bp = prv(bp);
    end else begin
      sz += sz_at(hdr(prv(bp))) + sz_at(hdr(nxt(bp)));
      wrw(hdr(prv(bp)), sz);
      wrw(ftr(nxt(bp)), sz);
      bp = prv(bp);
    end
    return bp;
  endfunction

  function automatic logic [31:0] grow_heap(logic [31:0] bytes);
    logic [31:0] words, sz, bp;
    words = bytes / WSIZE;
    sz = (words[0] ? words + 1 : words) * WSIZE;
    if (!bump_break(sz, bp)) return 32'd0;
    wrw(hdr(bp), sz);
    wrw(ftr(bp), sz);
    wrw(hdr(nxt(bp)), ALLOC_BIT);
    return merge_free(bp);
  endfunction

  function automatic logic [31:0] first_fit(logic [31:0] asize);
    logic [31:0] bp;
    int n;
    bp = list_head;
    for (n = 0; n < WALK_LIMIT && sz_at(hdr(bp)) > 0; n++) begin
      if (al_at(hdr(bp)) == 0 && asize <= sz_at(hdr(bp))) return bp;
      bp = nxt(bp);
    end
    return 32'd0;
  endfunction

  function automatic void carve(logic [31:0] bp, logic [31:0] asize);
    logic [31:0] cs;
    cs = sz_at(hdr(bp));
    if (cs - asize >= MIN_SPLIT) begin
      wrw(hdr(bp), asize | ALLOC_BIT);
      wrw(ftr(bp), asize | ALLOC_BIT);
      bp = nxt(bp);
      wrw(hdr(bp), cs - asize);
      wrw(ftr(bp), cs - asize);
    end else begin
      wrw(hdr(bp), cs | ALLOC_BIT);
      wrw(ftr(bp), cs | ALLOC_BIT);
    end
  endfunction

  function automatic logic [31:0] alloc_block(logic [31:0] size, output status_t st);
    logic [31:0] asize, bp;
    st = ST_OK;
    if (size == 0) begin
      st = ST_NULL;
      return 32'd0;
    end
    asize = (size <= DSIZE) ? 2 * DSIZE : DSIZE * ((size + DSIZE + (DSIZE - 1)) / DSIZE);
    bp = first_fit(asize);
    if (bp == 0) begin
      bp = grow_heap(asize > CHUNK_BYTES ? asize : CHUNK_BYTES);
      if (bp == 0) begin
        st = ST_NOMEM;
        return 32'd0;
      end
    end
    carve(bp, asize);
    return bp;
  endfunction

  function automatic void release_block(logic [31:0] bp);
    logic [31:0] sz;
    sz = sz_at(hdr(bp));
    wrw(hdr(bp), sz);
    wrw(ftr(bp), sz);
    void'(merge_free(bp));
  endfunction

  // expected response word for one accepted command word
  function automatic alloc_rsp_t predict_rsp(opcode_t op, logic [15:0] rsz, logic [15:0] bptr);
    alloc_rsp_t r;
    logic [31:0] size, ptr, res, cp, base;
    status_t st;
    size = {16'd0, rsz};
    ptr  = {16'd0, bptr};
    res  = 0;
    cp   = 0;
    st   = ST_OK;
    if (op == OP_INIT) begin
      brk = 0;
      heap_ready = 1'b0;
      if (bump_break(4 * WSIZE, base)) begin
        wrw(base, 32'd0);
        wrw(base + WSIZE, DSIZE | ALLOC_BIT);
        wrw(base + 2 * WSIZE, DSIZE | ALLOC_BIT);
        wrw(base + 3 * WSIZE, ALLOC_BIT);
        list_head = base + 2 * WSIZE;
        if (grow_heap(CHUNK_BYTES) != 0) heap_ready = 1'b1;
        else st = ST_NOMEM;
      end else begin
        st = ST_NOMEM;
      end
    end else if (!heap_ready) begin
      st = ST_UNINIT;
    end else if (op == OP_MALLOC) begin
      res = alloc_block(size, st);
    end else if (op == OP_FREE) begin
      if (ptr == 0) st = ST_NULL;
      else release_block(ptr);
    end else begin
      if (size == 0) begin
        if (ptr != 0) release_block(ptr);
        st = ST_NULL;
      end else if (ptr == 0) begin
        res = alloc_block(size, st);
      end else begin
        res = alloc_block(size, st);
        if (res != 0) begin
          cp = sz_at(hdr(ptr)) - DSIZE;
          if (size < cp) cp = size;
          release_block(ptr);
        end
      end
    end
    r.ptr = res[15:0];
    r.st  = st;
    r.cp  = cp[15:0];
    return r;
  endfunction

  task automatic report(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // predict on command words, compare on response words
  always @(posedge clk) begin
    alloc_rsp_t e;
    if (!rst_n) begin
      heap_img.delete();
      brk        = 0;
      list_head  = 0;
      heap_ready = 1'b0;
      fail_count = 0;
      rsp_q.delete();
      rsp_waiting <= 0;
    end else begin
      if (cmd.valid && cmd.ready)
        rsp_q.push_back(predict_rsp(cmd.opcode, cmd.request_size, cmd.block_ptr));
      if (rsp.valid && rsp.ready) begin
        if (rsp_q.size() == 0) begin
          report("response word with none expected");
        end else begin
          e = rsp_q.pop_front();
          if (rsp.result_ptr !== e.ptr)
            report($sformatf("result_ptr %h, expected %h", rsp.result_ptr, e.ptr));
          if (rsp.status !== e.st)
            report($sformatf("status %0d, expected %0d", rsp.status, e.st));
          if (rsp.copy_bytes !== e.cp)
            report($sformatf("copy_bytes %0d, expected %0d", rsp.copy_bytes, e.cp));
        end
      end
      rsp_waiting <= rsp_q.size();
    end
  end

endmodule

[tb/sv/tb_first_fit_heap_allocator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator
// Drives init, malloc, free and realloc command words with random gaps on
// both channels; after init frees and reallocs use live or null pointers.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  typedef struct {
    opcode_t     op;
    logic [15:0] old_ptr;
    int          gen;
  } sent_cmd_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   rsp_waiting;

  ffha_cmd_if in_cmd ();
  ffha_rsp_if out_rsp ();

  first_fit_heap_allocator uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_cmd  (in_cmd.sink),
    .out_rsp (out_rsp.source)
  );

  ffha_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (in_cmd),
    .rsp         (out_rsp),
    .fail_count  (fail_count),
    .rsp_waiting (rsp_waiting)
  );

  // live payloads and commands still awaiting their response word
  logic [15:0] live [$];
  sent_cmd_t   in_flight [$];
  int          heap_gen;
  bit          long_hold_req;
  bit          quiet;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // response side: random stalls plus one long hold-off
  always @(posedge clk) begin
    int off_left;
    if (!rst_n) begin
      off_left = 0;
      out_rsp.ready <= 1'b0;
    end else if (off_left > 0) begin
      off_left--;
      out_rsp.ready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      off_left = 400;
      out_rsp.ready <= 1'b0;
    end else begin
      out_rsp.ready <= 1'b1;
      if (!quiet && $urandom_range(0, 9) == 0) off_left = pick_gap();
    end
  end

  // learn live payloads from response words
  always @(posedge clk) begin
    sent_cmd_t s;
    if (rst_n && out_rsp.valid && out_rsp.ready && in_flight.size() > 0) begin
      s = in_flight.pop_front();
      if (s.gen == heap_gen) begin
        if ((s.op == OP_MALLOC || s.op == OP_REALLOC) && out_rsp.status == ST_OK &&
            out_rsp.result_ptr != 0)
          live.push_back(out_rsp.result_ptr);
        if (s.op == OP_REALLOC && out_rsp.status == ST_NOMEM && s.old_ptr != 0)
          live.push_back(s.old_ptr);
      end
    end
  end

  task automatic send(opcode_t op, logic [15:0] rsz, logic [15:0] bptr);
    sent_cmd_t s;
    int g;
    in_cmd.valid        <= 1'b1;
    in_cmd.opcode       <= op;
    in_cmd.request_size <= rsz;
    in_cmd.block_ptr    <= bptr;
    do @(posedge clk); while (!in_cmd.ready);
    s.op = op;
    s.old_ptr = bptr;
    s.gen = heap_gen;
    in_flight.push_back(s);
    if (op == OP_INIT) begin
      heap_gen++;
      live.delete();
    end
    g = pick_gap();
    if (g > 0) begin
      in_cmd.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // stop offering and wait for every response word
  task automatic drain();
    in_cmd.valid <= 1'b0;
    while (in_flight.size() > 0) @(posedge clk);
  endtask

  // takes a random live payload out of the list; 0 when none
  function automatic logic [15:0] take_live();
    int i;
    logic [15:0] p;
    if (live.size() == 0) return 16'd0;
    i = $urandom_range(0, live.size() - 1);
    p = live[i];
    live.delete(i);
    return p;
  endfunction

  function automatic logic [15:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(1, 200));
    if (r < 90) return 16'($urandom_range(201, 4200));
    if (r < 95) return 16'd0;
    return 16'($urandom_range(0, 65535));
  endfunction

  // stimulus
  initial begin
    int r, n;
    logic [15:0] p;
    clk = 1'b0;
    rst_n = 1'b0;
    in_cmd.valid = 1'b0;
    in_cmd.opcode = OP_INIT;
    in_cmd.request_size = 16'd0;
    in_cmd.block_ptr = 16'd0;
    heap_gen = 0;
    long_hold_req = 1'b0;
    quiet = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: commands before init, size corners, null pointers
    send(OP_MALLOC, 16'd0, 16'hFFFF);
    send(OP_MALLOC, 16'hFFFF, 16'd0);
    send(OP_FREE, 16'd0, 16'hFFFF);
    send(OP_REALLOC, 16'd5, 16'hFFFF);
    send(OP_FREE, 16'hFFFF, 16'd0);
    send(OP_INIT, 16'hFFFF, 16'hFFFF);
    send(OP_MALLOC, 16'd0, 16'd0);
    send(OP_MALLOC, 16'd1, 16'd0);
    send(OP_MALLOC, 16'd8, 16'd0);
    send(OP_MALLOC, 16'd9, 16'd0);
    send(OP_MALLOC, 16'd16, 16'd0);
    send(OP_MALLOC, 16'hFFFF, 16'd0);
    send(OP_FREE, 16'd0, 16'd0);
    send(OP_REALLOC, 16'd0, 16'd0);
    send(OP_REALLOC, 16'd24, 16'd0);
    drain();
    send(OP_FREE, 16'd0, take_live());
    send(OP_REALLOC, 16'd100, take_live());
    send(OP_REALLOC, 16'd0, take_live());
    send(OP_REALLOC, 16'hFFFF, take_live());
    send(OP_MALLOC, 16'd4096, 16'd0);
    send(OP_MALLOC, 16'd4090, 16'd0);
    drain();
    send(OP_REALLOC, 16'd3, take_live());
    send(OP_INIT, 16'd0, 16'd0);

    // random: mostly well-formed use of live payloads
    for (n = 0; n < 860; n++) begin
      if (n % 200 == 100) quiet = !quiet;
      if (n == 400) long_hold_req = 1'b1;
      r = $urandom_range(0, 999);
      if (r < 15) begin
        send(OP_INIT, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      end else if (r < 25) begin
        // fill the heap until it runs out
        repeat (20) send(OP_MALLOC, 16'($urandom_range(3000, 4000)), 16'd0);
      end else if (r < 450 && live.size() < 40) begin
        send(OP_MALLOC, pick_size(), 16'($urandom_range(0, 65535)));
      end else if (r < 480) begin
        send(OP_FREE, 16'($urandom_range(0, 65535)), 16'd0);
      end else if (r < 500) begin
        send(OP_REALLOC, pick_size(), 16'd0);
      end else begin
        if (live.size() == 0) drain();
        p = take_live();
        if (p == 0) send(OP_MALLOC, pick_size(), 16'd0);
        else if (r < 780) send(OP_FREE, 16'($urandom_range(0, 65535)), p);
        else send(OP_REALLOC, pick_size(), p);
      end
    end

    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && rsp_waiting == 0) begin
      $display("first_fit_heap_allocator test passed");
    end else begin
      $display("first_fit_heap_allocator test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200000000;
    $display("first_fit_heap_allocator test failed");
    $finish;
  end

endmodule
